/* sv/tcsb_pkg.sv */
// shared types, constants and codes for the text console scrollback buffer
`default_nettype none
package tcsb_pkg;

  localparam int LINES_DEF   = 512;
  localparam int COLUMNS_DEF = 80;

  // config register indexes
  localparam logic [1:0] CFG_ATTR = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_DISP = 2'd2;

  localparam logic [7:0] ATTR_RST = 8'd15;
  localparam logic [9:0] ROWS_RST = 10'd25;
  localparam logic       DISP_RST = 1'b1;

  // request op codes
  localparam logic [2:0] OP_CHAR   = 3'd0;
  localparam logic [2:0] OP_SCR_UP = 3'd1;
  localparam logic [2:0] OP_SCR_DN = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // control characters
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    K_PRINT,
    K_NEWLINE,
    K_RETURN,
    K_BACKSPACE,
    K_SCROLL_UP,
    K_SCROLL_DOWN,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [8:0] line_offset;
    logic [6:0] column;
  } cmd_t;

  typedef struct packed {
    logic [7:0] cell_attribute;
    logic [9:0] rows_shown;
    logic       display_on;
  } cfg_t;

endpackage
`default_nettype wire

/* sv/tcsb_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module tcsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

/* sv/tcsb_front.sv */
// request intake: decode into commands and a two-entry command queue
`default_nettype none
module tcsb_front
  import tcsb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] op_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [8:0] line_offset_i,
  input  wire logic [6:0] column_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);

  cmd_t       q_mem_q [2];
  cmd_t       dec;
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    dec.ch          = char_code_i;
    dec.line_offset = line_offset_i;
    dec.column      = column_i;
    dec.kind        = K_NOP;
    unique case (op_i)
      OP_CHAR: begin
        if (char_code_i == CH_NL) dec.kind = K_NEWLINE;
        else if (char_code_i == CH_CR) dec.kind = K_RETURN;
        else if (char_code_i == CH_BS) dec.kind = K_BACKSPACE;
        else dec.kind = K_PRINT;
      end
      OP_SCR_UP: dec.kind = K_SCROLL_UP;
      OP_SCR_DN: dec.kind = K_SCROLL_DOWN;
      OP_CLEAR:  dec.kind = K_CLEAR;
      OP_READ:   dec.kind = K_READ;
      default:   dec.kind = K_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_ready_i && cmd_valid_o;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wp_q] <= dec;
    end
  end

endmodule
`default_nettype wire

/* sv/tcsb_back.sv */
// command execution: line ring, cell banks, view logic and result register
`default_nettype none
module tcsb_back
  import tcsb_pkg::*;
#(
  parameter int LINES   = LINES_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_ready_o,
  input  wire cmd_t        cmd_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [59:0] out_data_o
);

  localparam int LW  = $clog2(LINES);
  localparam int NW  = $clog2(LINES + 1);
  localparam int RW  = (NW > 10) ? NW : 10;
  localparam int CCW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int LNW = $clog2(COLUMNS + 1);
  localparam int SW  = ((LW > 9) ? LW : 9) + 1;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_ADV  = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [LW-1:0]  sweep_q, sweep_d;
  logic [7:0]     sweep_attr_q, sweep_attr_d;
  logic [LW-1:0]  oldest_q, oldest_d;
  logic [NW-1:0]  stored_q, stored_d;
  logic [LW-1:0]  cur_q, cur_d;
  logic [CCW-1:0] col_q, col_d;
  logic [LNW-1:0] len_q, len_d;
  logic [LW-1:0]  view_q, view_d;
  logic           follow_q, follow_d;
  logic [CCW-1:0] rd_col_q, rd_col_d;
  logic           rd_ok_q, rd_ok_d;
  logic           out_valid_q, out_valid_d;
  logic [59:0]    out_data_q;

  logic [COLUMNS-1:0] bank_we;
  logic [LW-1:0]      bank_addr;
  logic [15:0]        bank_wdata;
  logic [15:0]        bank_rdata [COLUMNS];

  logic [15:0]    blank, rd_cell;
  logic [RW-1:0]  rows_eff, stored_x, view_x;
  logic [RW:0]    view_rows;
  logic           follow_now, out_free, emit;
  logic [LNW-1:0] col_inc;
  logic [CCW-1:0] col_dec;
  logic [LW-1:0]  nxt_line, view_tmp;
  logic [SW-1:0]  rd_sum;

  function automatic logic [LW-1:0] pin_view(input logic [NW-1:0] s, input logic [RW-1:0] r);
    logic [RW-1:0] sx;
    sx = RW'(s);
    if (sx > r) return LW'(sx - r);
    return '0;
  endfunction

  for (genvar c = 0; c < COLUMNS; c++) begin : g_bank
    tcsb_ram #(.WIDTH(16), .DEPTH(LINES)) u_bank (
      .clk_i  (clk_i),
      .we_i   (bank_we[c]),
      .addr_i (bank_addr),
      .wdata_i(bank_wdata),
      .rdata_o(bank_rdata[c])
    );
  end

  always_comb begin
    blank = {cfg_i.cell_attribute, CH_SPACE};
    if (cfg_i.rows_shown == 10'd0) rows_eff = RW'(1);
    else if (RW'(cfg_i.rows_shown) > RW'(LINES)) rows_eff = RW'(LINES);
    else rows_eff = RW'(cfg_i.rows_shown);
    stored_x   = RW'(stored_q);
    view_x     = RW'(view_q);
    view_rows  = {1'b0, view_x} + {1'b0, rows_eff};
    follow_now = (stored_x <= rows_eff) || (view_rows >= {1'b0, stored_x});
    out_free   = !out_valid_q || out_ready_i;
    col_inc    = LNW'(col_q) + LNW'(1);
    col_dec    = col_q - CCW'(1);
    nxt_line   = (cur_q == LW'(LINES - 1)) ? '0 : cur_q + LW'(1);
    rd_sum     = SW'(oldest_q) + SW'(cmd_i.line_offset);
    if (rd_sum >= SW'(LINES)) rd_sum = rd_sum - SW'(LINES);
  end

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    sweep_attr_d = sweep_attr_q;
    oldest_d     = oldest_q;
    stored_d     = stored_q;
    cur_d        = cur_q;
    col_d        = col_q;
    len_d        = len_q;
    view_d       = view_q;
    follow_d     = follow_q;
    rd_col_d     = rd_col_q;
    rd_ok_d      = rd_ok_q;
    view_tmp     = view_q;
    bank_we      = '0;
    bank_addr    = cur_q;
    bank_wdata   = blank;
    rd_cell      = 16'd0;
    emit         = 1'b0;
    cmd_ready_o  = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        // clearing pass, one line of every bank per cycle
        bank_we    = '1;
        bank_addr  = sweep_q;
        bank_wdata = {sweep_attr_q, CH_SPACE};
        sweep_d    = sweep_q + LW'(1);
        if (sweep_q == LW'(LINES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.kind)
            K_PRINT: begin
              for (int c = 0; c < COLUMNS; c++) bank_we[c] = (CCW'(c) == col_q);
              bank_wdata = {cfg_i.cell_attribute, cmd_i.ch};
              if (len_q < col_inc) len_d = col_inc;
              if (col_inc == LNW'(COLUMNS)) begin
                follow_d = follow_now;
                state_d  = ST_ADV;
              end else begin
                col_d = CCW'(col_inc);
                if (follow_now && cfg_i.display_on) view_d = pin_view(stored_q, rows_eff);
                emit = 1'b1;
              end
            end
            K_NEWLINE: begin
              // blank the tail of the current line
              for (int c = 0; c < COLUMNS; c++) bank_we[c] = (LNW'(c) >= len_q);
              follow_d = follow_now;
              state_d  = ST_ADV;
            end
            K_RETURN: begin
              col_d = '0;
              if (follow_now && cfg_i.display_on) view_d = pin_view(stored_q, rows_eff);
              emit = 1'b1;
            end
            K_BACKSPACE: begin
              if (col_q != '0) begin
                for (int c = 0; c < COLUMNS; c++) bank_we[c] = (CCW'(c) == col_dec);
                col_d = col_dec;
                if (len_q > LNW'(col_dec)) len_d = LNW'(col_dec);
              end
              if (follow_now && cfg_i.display_on) view_d = pin_view(stored_q, rows_eff);
              emit = 1'b1;
            end
            K_SCROLL_UP: begin
              if (cfg_i.display_on && view_q != '0) view_d = view_q - LW'(1);
              emit = 1'b1;
            end
            K_SCROLL_DOWN: begin
              if (cfg_i.display_on && (view_rows < {1'b0, stored_x})) view_d = view_q + LW'(1);
              emit = 1'b1;
            end
            K_CLEAR: begin
              oldest_d     = '0;
              stored_d     = NW'(1);
              cur_d        = '0;
              col_d        = '0;
              len_d        = '0;
              view_d       = '0;
              sweep_d      = '0;
              sweep_attr_d = cfg_i.cell_attribute;
              state_d      = ST_INIT;
              emit         = 1'b1;
            end
            K_READ: begin
              bank_addr = LW'(rd_sum);
              rd_ok_d   = (SW'(cmd_i.line_offset) < SW'(stored_q)) &&
                          ({1'b0, cmd_i.column} < 8'(COLUMNS));
              rd_col_d  = CCW'(cmd_i.column);
              state_d   = ST_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_ADV: begin
        // open the next line of the ring
        bank_we   = '1;
        bank_addr = nxt_line;
        cur_d     = nxt_line;
        col_d     = '0;
        len_d     = '0;
        if (stored_q < NW'(LINES)) begin
          stored_d = stored_q + NW'(1);
        end else begin
          oldest_d = (oldest_q == LW'(LINES - 1)) ? '0 : oldest_q + LW'(1);
          if (view_q != '0) view_tmp = view_q - LW'(1);
        end
        view_d = view_tmp;
        if (follow_q && cfg_i.display_on) view_d = pin_view(stored_d, rows_eff);
        emit    = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        rd_cell = blank;
        if (rd_ok_q) begin
          for (int c = 0; c < COLUMNS; c++) begin
            if (CCW'(c) == rd_col_q) rd_cell = bank_rdata[c];
          end
        end
        emit    = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      sweep_q      <= '0;
      sweep_attr_q <= ATTR_RST;
      oldest_q     <= '0;
      stored_q     <= NW'(1);
      cur_q        <= '0;
      col_q        <= '0;
      len_q        <= '0;
      view_q       <= '0;
      follow_q     <= 1'b0;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      sweep_attr_q <= sweep_attr_d;
      oldest_q     <= oldest_d;
      stored_q     <= stored_d;
      cur_q        <= cur_d;
      col_q        <= col_d;
      len_q        <= len_d;
      view_q       <= view_d;
      follow_q     <= follow_d;
      rd_ok_q      <= rd_ok_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_col_q <= rd_col_d;
    if (emit) begin
      out_data_q <= {7'(col_d), 9'(cur_d), 9'(oldest_d), 10'(stored_d), 9'(view_d), rd_cell};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

/* sv/text_console_scrollback_buffer_unit.sv */
// top level of the text console scrollback buffer
//
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           request: op, char_code, line_offset, column
// m_axis    out  tvalid/tready           status: cell, view, counts, cursor
// cfg       in   cfg_we_i (no wait)      cell_attribute, rows_shown, display_on
//
// after reset a clearing pass writes blanks to every line; the executor takes
// no command meanwhile, though the queue may; a clear request starts the same pass
// printable, return, backspace and scroll complete in the executor's idle state;
// newline, wrap and read also pass ST_ADV (second write) or ST_READ (ram read)
// a two-entry command queue lets intake run ahead of the executor; a full
// result register stalls the executor only
`default_nettype none
module text_console_scrollback_buffer_unit
  import tcsb_pkg::*;
#(
  parameter int LINES   = LINES_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[2:0], char_code[10:3], line_offset[19:11], column[26:20], zero pad
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cell_value[15:0], view_top[24:16], line_count[34:25], oldest_line[43:35],
  // cursor_line[52:44], cursor_column[59:53], zero pad
  output logic      [63:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i
);

  cfg_t        cfg_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  logic [59:0] out_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_attribute <= ATTR_RST;
      cfg_q.rows_shown     <= ROWS_RST;
      cfg_q.display_on     <= DISP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATTR: cfg_q.cell_attribute <= cfg_data_i[7:0];
        CFG_ROWS: cfg_q.rows_shown     <= cfg_data_i;
        CFG_DISP: cfg_q.display_on     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // intake and decode
  tcsb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tdata[2:0]),
    .char_code_i  (s_axis_tdata[10:3]),
    .line_offset_i(s_axis_tdata[19:11]),
    .column_i     (s_axis_tdata[26:20]),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  // executor with cell banks and result register
  tcsb_back #(
    .LINES  (LINES),
    .COLUMNS(COLUMNS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_data)
  );

  assign m_axis_tdata = {4'd0, out_data};

endmodule
`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the text console scrollback buffer unit
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import tcsb_pkg::*;

  localparam int NLINES = 512;
  localparam int NCOLS  = 80;
  localparam int WATCHDOG_LIMIT = 20000;

  // one status word as returned by the block
  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [8:0]  cursor_line;
    logic [8:0]  oldest_line;
    logic [9:0]  line_count;
    logic [8:0]  view_top;
    logic [15:0] cell_value;
  } status_t;

  // console shadow: screen contents, pointers, register values
  class console_scoreboard;
    logic [15:0] screen [NLINES][NCOLS];
    logic [6:0]  row_len [NLINES];
    int unsigned oldest, nlines, cur_row, cur_col, view;
    int unsigned attr, rows_reg, disp;
    status_t     pending_status [$];
    int          errors;

    function new();
      errors = 0;
      attr = ATTR_RST; rows_reg = ROWS_RST; disp = DISP_RST;
      wipe();
    endfunction

    function logic [15:0] blank();
      return {attr[7:0], CH_SPACE};
    endfunction

    function int unsigned rows_eff();
      int unsigned r;
      r = rows_reg > NLINES ? NLINES : rows_reg;
      return r == 0 ? 1 : r;
    endfunction

    function void blank_row(int unsigned ln);
      for (int c = 0; c < NCOLS; c++) screen[ln][c] = blank();
      row_len[ln] = 0;
    endfunction

    function void wipe();
      for (int l = 0; l < NLINES; l++) blank_row(l);
      oldest = 0; nlines = 1; cur_row = 0; cur_col = 0; view = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        CFG_ATTR: attr = val[7:0];
        CFG_ROWS: rows_reg = val;
        CFG_DISP: disp = val[0];
        default: ;
      endcase
    endfunction

    // newline: blank the tail of the line and move the ring forward
    function void next_line();
      int unsigned from;
      from = row_len[cur_row];
      for (int c = from; c < NCOLS; c++) screen[cur_row][c] = blank();
      cur_col = 0;
      cur_row = (cur_row + 1) % NLINES;
      if (nlines < NLINES) nlines++;
      else begin
        oldest = (oldest + 1) % NLINES;
        if (view > 0) view--;
      end
      blank_row(cur_row);
    endfunction

    function void put_char(logic [7:0] ch);
      int unsigned r;
      bit follow;
      r = rows_eff();
      follow = (nlines <= r) || (view + r >= nlines);
      if (ch == CH_NL) next_line();
      else if (ch == CH_CR) cur_col = 0;
      else if (ch == CH_BS) begin
        if (cur_col > 0) begin
          cur_col--;
          screen[cur_row][cur_col] = blank();
          if (row_len[cur_row] > cur_col) row_len[cur_row] = 7'(cur_col);
        end
      end else begin
        if (cur_col >= NCOLS) next_line();
        screen[cur_row][cur_col] = {attr[7:0], ch};
        cur_col++;
        if (row_len[cur_row] < cur_col) row_len[cur_row] = 7'(cur_col);
        if (cur_col >= NCOLS) next_line();
      end
      if (follow && disp) view = nlines > r ? nlines - r : 0;
    endfunction

    // note an accepted request and queue the status it should produce
    function void note_request(logic [31:0] data);
      logic [2:0] op;
      logic [8:0] off;
      logic [6:0] col;
      status_t s;
      op = data[2:0]; off = data[19:11]; col = data[26:20];
      s = '0;
      case (op)
        OP_CHAR:   put_char(data[10:3]);
        OP_SCR_UP: if (disp && view > 0) view--;
        OP_SCR_DN: if (disp && view + rows_eff() < nlines) view++;
        OP_CLEAR:  wipe();
        OP_READ:
          if (off < nlines && col < NCOLS) s.cell_value = screen[(oldest + off) % NLINES][col];
          else s.cell_value = blank();
        default: ;
      endcase
      s.view_top = 9'(view); s.line_count = 10'(nlines); s.oldest_line = 9'(oldest);
      s.cursor_line = 9'(cur_row); s.cursor_column = 7'(cur_col);
      pending_status.push_back(s);
    endfunction

    function void check_status(logic [63:0] data);
      status_t got, exp;
      got = data[59:0];
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected status, actual %h", $time, got);
        errors++;
        return;
      end
      exp = pending_status.pop_front();
      if (data[63:60] != 0 || got != exp) begin
        $display("%0t: status mismatch, expected %h actual %h", $time, exp, data);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [9:0]  cfg_data_i = '0;

  console_scoreboard sb;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;
  int  quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  text_console_scrollback_buffer_unit u_dut (.*);

  // sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
  end

  // receiver backpressure, changed at the falling edge
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [31:0] pack_req(logic [2:0] op, logic [7:0] ch,
                                           logic [8:0] off, logic [6:0] col);
    return {5'b0, col, off, ch, op};
  endfunction

  // offer one request, held until taken; random idle before it
  task automatic send_req(logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_char(logic [7:0] ch);
    send_req(pack_req(OP_CHAR, ch, 9'($urandom), 7'($urandom)));
  endtask

  task automatic send_read(logic [8:0] off, logic [6:0] col);
    send_req(pack_req(OP_READ, 8'($urandom), off, col));
  endtask

  // drain results and leave the request side idle, so a register can be written while idle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_status.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // random request mix: mostly text with newlines, some scrolls and reads
  task automatic random_req();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) send_char(8'($urandom_range(32, 126)));
    else if (p < 62) send_char(CH_NL);
    else if (p < 65) send_char(CH_CR);
    else if (p < 68) send_char(CH_BS);
    else if (p < 71) send_char(8'($urandom));
    else if (p < 76)
      send_req(pack_req(OP_SCR_UP, 8'($urandom), 9'($urandom), 7'($urandom)));
    else if (p < 81)
      send_req(pack_req(OP_SCR_DN, 8'($urandom), 9'($urandom), 7'($urandom)));
    else if (p < 82)
      send_req(pack_req(3'($urandom_range(5, 7)), 8'($urandom), 9'($urandom), 7'($urandom)));
    else if (p < 94)
      send_read(9'($urandom_range(0, sb.nlines)), 7'($urandom_range(0, NCOLS - 1)));
    else if (p < 99) send_read(9'($urandom), 7'($urandom));
    else if ($urandom_range(9) == 0)
      send_req(pack_req(OP_CLEAR, 8'($urandom), 9'($urandom), 7'($urandom)));
    else send_char(CH_NL);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes of fields, every op, special cases
    send_read(0, 0);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_BS);
    send_char(CH_BS);
    send_char(CH_BS);                 // backspace at column 0
    for (int i = 0; i < 81; i++) send_char(8'(8'h41 + i % 26));  // wrap at last column
    send_char(CH_CR);
    send_char(CH_NL);
    send_req(pack_req(OP_SCR_UP, 0, 0, 0));
    send_req(pack_req(OP_SCR_DN, 0, 0, 0));
    send_read(0, 79);
    send_read(1, 127);                // column past the end
    send_read(9'h1FF, 0);             // line past the stored ones
    send_req(pack_req(3'd7, 8'hFF, 9'h1FF, 7'h7F));
    send_req(pack_req(3'd5, 0, 0, 0));
    send_req(pack_req(OP_CLEAR, 0, 0, 0));
    wait_idle();

    // deep scrollback: fill the ring past full with rows_shown small
    write_reg(CFG_ROWS, 10'd1);
    write_reg(CFG_ATTR, 10'hFF);
    for (int i = 0; i < 530; i++) send_char(CH_NL);
    for (int i = 0; i < 8; i++) send_req(pack_req(OP_SCR_UP, 0, 0, 0));
    send_char(8'h58);                 // not following: view stays put
    for (int i = 0; i < 4; i++) send_req(pack_req(OP_SCR_DN, 0, 0, 0));
    send_read(9'd511, 0);
    wait_idle();

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 30; i++) random_req();
    join
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 22; recv_idle_pct = 74; end
        1: begin send_idle_pct = 74; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: begin
          write_reg(CFG_ATTR, 10'd0); write_reg(CFG_ROWS, 10'd512); write_reg(CFG_DISP, 10'd0);
        end
        1: begin
          write_reg(CFG_ATTR, 10'($urandom)); write_reg(CFG_ROWS, 10'd0);
          write_reg(CFG_DISP, 10'd1);
        end
        default: begin
          write_reg(CFG_ATTR, 10'hA5); write_reg(CFG_ROWS, 10'h3FF);
          write_reg(CFG_DISP, 10'd1);
        end
      endcase
      for (int i = 0; i < 70; i++) random_req();
      wait_idle();
      write_reg(CFG_ROWS, 10'($urandom_range(1, 40)));
      for (int i = 0; i < 70; i++) random_req();
      wait_idle();
    end

    repeat (50) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_status.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
`default_nettype wire
